// File: hdl/cosine_similarity_engine_macros.svh
// assertion macros shared by the cosine similarity engine
// they expect clk and rst_n in scope
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// same-cycle implication
`define CSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// types and constants of the cosine similarity engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int DOT_W            = 43;
    localparam int SQ_W             = 41;
    localparam int SIM_W            = 16;
    localparam int STATUS_W         = 2;
    localparam int MUL_W            = 43;
    localparam int PROD_W           = 2 * MUL_W;
    localparam int MUL_CNT_W        = 6;
    localparam int Q_W              = 15;
    localparam int K_W              = 4;
    localparam int P_W              = 2 * SQ_W;
    localparam int T_W              = P_W + Q_W;
    localparam int R_W              = PROD_W + 28;
    localparam int S_W              = R_W + 2;

    localparam logic [Q_W-1:0]       ONE_Q14   = 15'd16384;
    localparam logic [K_W-1:0]       K_TOP     = 4'd14;
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 6'd43;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_MAG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic accumulate;
        logic mul_load_p;
        logic mul_load_d;
        logic mul_step;
        logic srch_init;
        logic srch_step;
        logic load_out;
    } cse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic zero_mag;
        logic mul_last;
        logic srch_last;
        logic out_free;
    } cse_stat_t;

endpackage

// File: hdl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl
// sequencer: accumulate pairs, then two serial multiplies and the q search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_ctrl
    import cse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cse_stat_t stat,
    output cse_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ACC    = 8'b0000_0010,
        ST_MULP_L = 8'b0000_0100,
        ST_MULP   = 8'b0000_1000,
        ST_MULD_L = 8'b0001_0000,
        ST_MULD   = 8'b0010_0000,
        ST_SRCH   = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = stat.last ? ST_MULP_L : ST_IDLE;
            end
            ST_MULP_L:
            begin
                if (stat.zero_mag)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.mul_load_p = 1'b1;
                    state_next     = ST_MULP;
                end
            end
            ST_MULP:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_MULD_L;
                end
            end
            ST_MULD_L:
            begin
                cmd.mul_load_d = 1'b1;
                state_next     = ST_MULD;
            end
            ST_MULD:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (!cmd.srch_init && stat.srch_last)
                begin
                    state_next = ST_FIN;
                end
                cmd.srch_step = 1'b1;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // search setup happens on the last multiply step
        if (state_reg == ST_MULD && stat.mul_last)
        begin
            cmd.srch_init = 1'b1;
        end
    end

endmodule

// File: hdl/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath
// accumulators, shared shift-add multiplier, bitwise q search, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cosine_similarity_engine_macros.svh"

module cse_datapath
    import cse_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cse_cmd_t                      cmd,
    output cse_stat_t                     stat,
    input  logic signed [SAMPLE_BITS-1:0] in_a,
    input  logic signed [SAMPLE_BITS-1:0] in_b,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SIM_W-1:0]       out_sim,
    output logic signed [DOT_W-1:0]       out_dot,
    output logic [STATUS_W-1:0]           out_status
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam int PR_W = 2 * SAMPLE_BITS;

    // input item registers
    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg;
    logic                          last_reg;

    // accumulators
    logic signed [DOT_W-1:0] dot_reg;
    logic [SQ_W-1:0]         sqa_reg, sqb_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    // multiplier
    logic [PROD_W-1:0]    mcand_reg, prod_reg;
    logic [MUL_W-1:0]     mplier_reg;
    logic [MUL_CNT_W-1:0] mcnt_reg;

    // search
    logic [P_W-1:0]   p_reg;
    logic [R_W-1:0]   r_reg;
    logic [S_W-1:0]   s_reg;
    logic [T_W-1:0]   t_reg;
    logic [Q_W-1:0]   q_reg;
    logic [K_W-1:0]   k_reg;

    // result
    logic                    ov_reg;
    logic signed [SIM_W-1:0] osim_reg;
    logic signed [DOT_W-1:0] odot_reg;
    logic [STATUS_W-1:0]     ost_reg;

    // per-pair products and saturating sums
    logic signed [PR_W-1:0]  prod_ab, sq_a, sq_b;
    logic signed [DOT_W:0]   dot_wide;
    logic [SQ_W:0]           sqa_wide, sqb_wide;
    logic signed [DOT_W-1:0] dot_next;
    logic [SQ_W-1:0]         sqa_next, sqb_next;
    logic [MUL_W-1:0]        dot_mag;

    assign prod_ab  = a_reg * b_reg;
    assign sq_a     = a_reg * a_reg;
    assign sq_b     = b_reg * b_reg;
    assign dot_wide = {dot_reg[DOT_W-1], dot_reg}
                    + {{(DOT_W + 1 - PR_W){prod_ab[PR_W-1]}}, prod_ab};
    assign sqa_wide = {1'b0, sqa_reg} + (SQ_W + 1)'(unsigned'(sq_a));
    assign sqb_wide = {1'b0, sqb_reg} + (SQ_W + 1)'(unsigned'(sq_b));

    always_comb
    begin
        if (dot_wide[DOT_W] != dot_wide[DOT_W-1])
        begin
            dot_next = dot_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                       : {1'b0, {(DOT_W-1){1'b1}}};
        end
        else
        begin
            dot_next = dot_wide[DOT_W-1:0];
        end
        sqa_next = sqa_wide[SQ_W] ? {SQ_W{1'b1}} : sqa_wide[SQ_W-1:0];
        sqb_next = sqb_wide[SQ_W] ? {SQ_W{1'b1}} : sqb_wide[SQ_W-1:0];
    end

    // magnitude of the dot product, -2^42 maps to 2^42
    assign dot_mag = dot_reg[DOT_W-1] ? MUL_W'(~dot_reg + 1'b1) : MUL_W'(dot_reg);

    // candidate for the search at bit k
    logic [Q_W-1:0] q_cand;
    logic [S_W-1:0] s_cand;
    logic [T_W-1:0] t_cand;
    logic           take;

    assign q_cand = q_reg | (Q_W'(1) << k_reg);
    assign s_cand = s_reg + (S_W'(t_reg) << ({1'b0, k_reg} + 5'd1))
                          + (S_W'(p_reg) << {k_reg, 1'b0});
    assign t_cand = t_reg + (T_W'(p_reg) << k_reg);
    assign take   = (q_cand <= ONE_Q14) && (s_cand <= S_W'(r_reg));

    // input capture, serial multiplier and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg    <= in_a;
            b_reg    <= in_b;
            last_reg <= in_last;
        end
        if (cmd.mul_load_p)
        begin
            mcand_reg  <= PROD_W'(sqa_reg);
            mplier_reg <= MUL_W'(sqb_reg);
            prod_reg   <= '0;
            mcnt_reg   <= MUL_STEPS;
        end
        else if (cmd.mul_load_d)
        begin
            p_reg      <= prod_reg[P_W-1:0];
            mcand_reg  <= PROD_W'(dot_mag);
            mplier_reg <= dot_mag;
            prod_reg   <= '0;
            mcnt_reg   <= MUL_STEPS;
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            mcnt_reg   <= mcnt_reg - 1'b1;
        end
        if (cmd.srch_init)
        begin
            s_reg <= '0;
            t_reg <= '0;
            q_reg <= '0;
            k_reg <= K_TOP;
        end
        else if (cmd.srch_step)
        begin
            if (take)
            begin
                s_reg <= s_cand;
                t_reg <= t_cand;
                q_reg <= q_cand;
            end
            k_reg <= k_reg - 1'b1;
        end
        // the final multiply step lands in prod_reg together with srch_init
        if (cmd.srch_init)
        begin
            r_reg <= {(mplier_reg[0] ? prod_reg + mcand_reg : prod_reg), 28'b0};
        end
    end

    // accumulators and element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.accumulate)
        begin
            dot_reg <= dot_next;
            sqa_reg <= sqa_next;
            sqb_reg <= sqb_next;
            if (cnt_reg >= CNT_MAX)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // result register
    logic            zero_mag;
    logic [Q_W-1:0]  q_mag;

    assign zero_mag = (sqa_reg == '0) || (sqb_reg == '0);
    assign q_mag    = zero_mag ? '0 : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            osim_reg <= dot_reg[DOT_W-1] ? -SIM_W'(q_mag) : SIM_W'(q_mag);
            odot_reg <= dot_reg;
            if (ovf_reg)
            begin
                ost_reg <= STATUS_TOO_LONG;
            end
            else if (zero_mag)
            begin
                ost_reg <= STATUS_ZERO_MAG;
            end
            else
            begin
                ost_reg <= STATUS_OK;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign out_sim    = osim_reg;
    assign out_dot    = odot_reg;
    assign out_status = ost_reg;

    assign stat.last      = last_reg;
    assign stat.zero_mag  = zero_mag;
    assign stat.mul_last  = (mcnt_reg == MUL_CNT_W'(1));
    assign stat.srch_last = (k_reg == '0);
    assign stat.out_free  = !ov_reg || out_ready;

    // checks
    `CSE_ASSERT_IMP(a_q_bound, cmd.load_out, q_mag <= ONE_Q14)
    `CSE_ASSERT_NEXT(a_acc_clear, cmd.load_out,
        dot_reg == '0 && sqa_reg == '0 && sqb_reg == '0 && !ovf_reg)
    `CSE_ASSERT_NEXT(a_zero_status, cmd.load_out && zero_mag && !ovf_reg,
        ost_reg == STATUS_ZERO_MAG && osim_reg == '0)
    `CSE_ASSERT_IMP(a_load_free, cmd.load_out, !ov_reg || out_ready)

endmodule

// File: hdl/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// fixed-point cosine similarity of two streamed vectors
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                      tuser / tlast
// s_axis   in   element_a[15:0], element_b[31:16]       tlast = last_element
// m_axis   out  similarity[15:0], dot_value[58:16], 0s  tuser = status[1:0]
//
// each pair is captured, then accumulated with saturation
// after the last pair come two 43-step shift-add multiplies (sumA*sumB, then dot^2)
// and a 15-step bitwise search for q; the result register is loaded once it is free
// a zero magnitude skips the multiplies and the search; the result waits in an
// output register, a new item is taken once it has been loaded
// reset clears the accumulators and the result valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosine_similarity_engine
    import cse_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // element_a, element_b
    input  logic        s_axis_tlast,   // last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // similarity, dot_value, zero fill
    output logic [1:0]  m_axis_tuser    // status
);

    cse_cmd_t  cmd;
    cse_stat_t stat;

    logic signed [SIM_W-1:0] sim;
    logic signed [DOT_W-1:0] dot;
    logic [STATUS_W-1:0]     status;

    cse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cse_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_a       (s_axis_tdata[15:0]),
        .in_b       (s_axis_tdata[31:16]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sim    (sim),
        .out_dot    (dot),
        .out_status (status)
    );

    // pack result item
    assign m_axis_tdata = {5'b0, dot, sim};
    assign m_axis_tuser = status;

endmodule
